// ===== design/etl_pkg.sv =====
// ----------------------------------------------------------------------------
// etl_pkg
// Shared types, constants and character-class functions for the expression
// token lexer.
// ----------------------------------------------------------------------------
package etl_pkg;

    localparam int POSITION_BITS = 16;
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    // token queue between the scanner and the output stage
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    // token kinds
    localparam logic [4:0] K_DIR     = 5'd0;
    localparam logic [4:0] K_IDENT   = 5'd1;
    localparam logic [4:0] K_NUM     = 5'd2;
    localparam logic [4:0] K_SINGLE0 = 5'd3;
    localparam logic [4:0] K_PAIR0   = 5'd23;
    localparam logic [4:0] K_END     = 5'd30;
    localparam logic [4:0] K_NONE    = 5'd0;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_UNEXP    = 3'd1;
    localparam logic [2:0] ERR_BAD_DOT  = 3'd2;
    localparam logic [2:0] ERR_BAD_EXP  = 3'd3;
    localparam logic [2:0] ERR_TOO_LONG = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IDENT,
        ST_DIR,
        ST_DOT,
        ST_INT,
        ST_FRAC,
        ST_EXP_E,
        ST_EXP_REST,
        ST_HELD,
        ST_SKIP
    } scan_state_t;

    typedef struct packed {
        logic [4:0]               kind;
        logic [POSITION_BITS-1:0] tok_start;
        logic [POSITION_BITS-1:0] tok_end;
        logic [2:0]               err;
        logic                     last;
        logic                     done;
    } token_t;

    // up to two tokens written into the queue per cycle
    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } queue_wr_t;

    typedef struct packed {
        logic [QCNT_BITS-1:0] count;
    } queue_status_t;

    function automatic token_t mk_tok(input logic [4:0] kind,
                                      input logic [POSITION_BITS-1:0] s,
                                      input logic [POSITION_BITS-1:0] e,
                                      input logic [2:0] err,
                                      input logic done);
        token_t t;
        t.kind      = kind;
        t.tok_start = s;
        t.tok_end   = e;
        t.err       = err;
        t.last      = 1'b0;
        t.done      = done;
        return t;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic ident_head(input logic [7:0] c);
        return is_letter(c) || c == "_";
    endfunction

    function automatic logic ident_tail(input logic [7:0] c);
        return ident_head(c) || is_digit(c) || c == "[" || c == "]";
    endfunction

    function automatic logic is_holdable(input logic [7:0] c);
        return c == "&" || c == "|" || c == "=" || c == "!" ||
               c == "<" || c == ">" || c == "*";
    endfunction

    // K_NONE when the character is not a one-character operator
    function automatic logic [4:0] single_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            "(":     k = K_SINGLE0;
            ")":     k = K_SINGLE0 + 5'd1;
            "{":     k = K_SINGLE0 + 5'd2;
            "}":     k = K_SINGLE0 + 5'd3;
            ",":     k = K_SINGLE0 + 5'd4;
            "?":     k = K_SINGLE0 + 5'd5;
            ":":     k = K_SINGLE0 + 5'd6;
            "@":     k = K_SINGLE0 + 5'd7;
            "+":     k = K_SINGLE0 + 5'd8;
            "-":     k = K_SINGLE0 + 5'd9;
            "*":     k = K_SINGLE0 + 5'd10;
            "/":     k = K_SINGLE0 + 5'd11;
            "%":     k = K_SINGLE0 + 5'd12;
            "^":     k = K_SINGLE0 + 5'd13;
            "~":     k = K_SINGLE0 + 5'd14;
            "!":     k = K_SINGLE0 + 5'd15;
            "&":     k = K_SINGLE0 + 5'd16;
            "|":     k = K_SINGLE0 + 5'd17;
            "<":     k = K_SINGLE0 + 5'd18;
            ">":     k = K_SINGLE0 + 5'd19;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    // K_NONE when the two characters are not a two-character operator
    function automatic logic [4:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
        logic [4:0] k;
        k = K_NONE;
        if (a == "&" && b == "&") k = K_PAIR0;
        if (a == "|" && b == "|") k = K_PAIR0 + 5'd1;
        if (a == "=" && b == "=") k = K_PAIR0 + 5'd2;
        if (a == "!" && b == "=") k = K_PAIR0 + 5'd3;
        if (a == "<" && b == "=") k = K_PAIR0 + 5'd4;
        if (a == ">" && b == "=") k = K_PAIR0 + 5'd5;
        if (a == "*" && b == "*") k = K_PAIR0 + 5'd6;
        return k;
    endfunction

endpackage

// ===== design/etl_front.sv =====
// ----------------------------------------------------------------------------
// etl_front
// Character scanner: takes one byte or end mark per cycle while in_ready is
// high, tracks the token being built and queues zero, one or two finished tokens.
// ----------------------------------------------------------------------------
module etl_front
    import etl_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          in_end,
    input  queue_status_t q_status,
    output queue_wr_t     q_wr
);

    scan_state_t              state_reg, state_next;
    logic [POSITION_BITS-1:0] begin_reg, begin_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [7:0]               held_reg, held_next;
    logic                     seen_reg, seen_next;

    logic   accept;
    logic   va, vb, do_start;
    token_t ta, tb;

    // classification of the byte as the head of a new token
    scan_state_t st_state;
    logic        st_seen;
    logic [7:0]  st_held;
    logic        st_tok_v;
    token_t      st_tok;
    logic [4:0]  sk, pk;

    // room for two tokens so a worst-case transaction never overflows
    assign in_ready = q_status.count <= QCNT_BITS'(QDEPTH - 2);
    assign accept   = in_valid && in_ready;

    assign sk = single_kind(in_byte);
    assign pk = pair_kind(held_reg, in_byte);

    always_comb begin
        st_state = ST_IDLE;
        st_seen  = seen_reg;
        st_held  = held_reg;
        st_tok_v = 1'b0;
        st_tok   = mk_tok(sk, pos_reg, pos_reg + 1'b1, ERR_NONE, 1'b0);
        if (is_space(in_byte)) begin
            st_state = ST_IDLE;
        end else if (in_byte == ".") begin
            st_state = ST_DOT;
        end else if (is_digit(in_byte)) begin
            st_state = ST_INT;
            st_seen  = 1'b1;
        end else if (ident_head(in_byte)) begin
            st_state = ST_IDENT;
        end else if (is_holdable(in_byte)) begin
            st_state = ST_HELD;
            st_held  = in_byte;
        end else if (sk != K_NONE) begin
            st_state = ST_IDLE;
            st_tok_v = 1'b1;
        end else begin
            st_state = ST_SKIP;
            st_tok_v = 1'b1;
            st_tok   = mk_tok(K_END, pos_reg, pos_reg, ERR_UNEXP, 1'b1);
        end
    end

    always_comb begin
        state_next = state_reg;
        begin_next = begin_reg;
        pos_next   = pos_reg;
        held_next  = held_reg;
        seen_next  = seen_reg;
        va         = 1'b0;
        vb         = 1'b0;
        do_start   = 1'b0;
        ta         = mk_tok(K_NUM, begin_reg, pos_reg, ERR_NONE, 1'b0);
        tb         = mk_tok(K_END, pos_reg, pos_reg, ERR_NONE, 1'b1);

        if (in_end) begin
            vb = 1'b1;
            unique case (state_reg)
                ST_SKIP: begin
                    vb = 1'b0;
                end
                ST_IDENT: begin
                    va = 1'b1;
                    ta = mk_tok(K_IDENT, begin_reg, pos_reg, ERR_NONE, 1'b0);
                end
                ST_DIR: begin
                    va = 1'b1;
                    ta = mk_tok(K_DIR, begin_reg, pos_reg, ERR_NONE, 1'b0);
                end
                ST_INT, ST_FRAC: begin
                    va = 1'b1;
                end
                ST_EXP_REST: begin
                    va = 1'b1;
                    if (!seen_reg) begin
                        vb = 1'b0;
                        ta = mk_tok(K_END, pos_reg - 2'd2, pos_reg - 2'd2, ERR_BAD_EXP, 1'b1);
                    end
                end
                ST_EXP_E: begin
                    va = 1'b1;
                    vb = 1'b0;
                    ta = mk_tok(K_END, pos_reg - 1'b1, pos_reg - 1'b1, ERR_BAD_EXP, 1'b1);
                end
                ST_DOT: begin
                    va = 1'b1;
                    vb = 1'b0;
                    ta = mk_tok(K_END, begin_reg, begin_reg, ERR_BAD_DOT, 1'b1);
                end
                ST_HELD: begin
                    va = 1'b1;
                    if (held_reg == "=") begin
                        vb = 1'b0;
                        ta = mk_tok(K_END, begin_reg, begin_reg, ERR_UNEXP, 1'b1);
                    end else begin
                        ta = mk_tok(single_kind(held_reg), begin_reg, pos_reg, ERR_NONE, 1'b0);
                    end
                end
                default: begin
                end
            endcase
            state_next = ST_IDLE;
            begin_next = '0;
            pos_next   = '0;
            held_next  = '0;
            seen_next  = 1'b0;
        end else if (state_reg == ST_SKIP) begin
            // bytes after an error are dropped
        end else if (pos_reg == POS_MAX) begin
            va         = 1'b1;
            ta         = mk_tok(K_END, pos_reg, pos_reg, ERR_TOO_LONG, 1'b1);
            state_next = ST_SKIP;
        end else begin
            pos_next = pos_reg + 1'b1;
            unique case (state_reg)
                ST_IDENT, ST_DIR: begin
                    if (!ident_tail(in_byte)) begin
                        va       = 1'b1;
                        ta       = mk_tok(state_reg == ST_DIR ? K_DIR : K_IDENT,
                                          begin_reg, pos_reg, ERR_NONE, 1'b0);
                        do_start = 1'b1;
                    end
                end
                ST_DOT: begin
                    if (ident_head(in_byte)) begin
                        state_next = ST_DIR;
                    end else if (is_digit(in_byte)) begin
                        state_next = ST_FRAC;
                        seen_next  = 1'b1;
                    end else begin
                        va         = 1'b1;
                        ta         = mk_tok(K_END, begin_reg, begin_reg, ERR_BAD_DOT, 1'b1);
                        state_next = ST_SKIP;
                    end
                end
                ST_INT, ST_FRAC: begin
                    if (is_digit(in_byte)) begin
                        state_next = state_reg;
                    end else if (in_byte == "." && state_reg == ST_INT) begin
                        state_next = ST_FRAC;
                    end else if (in_byte == "e" || in_byte == "E") begin
                        state_next = ST_EXP_E;
                        seen_next  = 1'b0;
                    end else begin
                        va       = 1'b1;
                        do_start = 1'b1;
                    end
                end
                ST_EXP_E: begin
                    if (in_byte == "+" || in_byte == "-") begin
                        state_next = ST_EXP_REST;
                        seen_next  = 1'b0;
                    end else if (is_digit(in_byte)) begin
                        state_next = ST_EXP_REST;
                        seen_next  = 1'b1;
                    end else begin
                        va         = 1'b1;
                        ta         = mk_tok(K_END, pos_reg - 1'b1, pos_reg - 1'b1,
                                            ERR_BAD_EXP, 1'b1);
                        state_next = ST_SKIP;
                    end
                end
                ST_EXP_REST: begin
                    if (is_digit(in_byte)) begin
                        seen_next = 1'b1;
                    end else if (seen_reg) begin
                        va       = 1'b1;
                        do_start = 1'b1;
                    end else begin
                        va         = 1'b1;
                        ta         = mk_tok(K_END, pos_reg - 2'd2, pos_reg - 2'd2,
                                            ERR_BAD_EXP, 1'b1);
                        state_next = ST_SKIP;
                    end
                end
                ST_HELD: begin
                    va = 1'b1;
                    if (pk != K_NONE) begin
                        ta         = mk_tok(pk, begin_reg, pos_reg + 1'b1, ERR_NONE, 1'b0);
                        state_next = ST_IDLE;
                    end else if (held_reg == "=") begin
                        // lone '=' also swallows the byte after it
                        ta         = mk_tok(K_END, begin_reg, begin_reg, ERR_UNEXP, 1'b1);
                        state_next = ST_SKIP;
                    end else begin
                        ta       = mk_tok(single_kind(held_reg), begin_reg, pos_reg,
                                          ERR_NONE, 1'b0);
                        do_start = 1'b1;
                    end
                end
                default: begin
                    do_start = 1'b1;
                end
            endcase
            if (do_start) begin
                state_next = st_state;
                begin_next = pos_reg;
                seen_next  = st_seen;
                held_next  = st_held;
                vb         = st_tok_v;
                tb         = st_tok;
            end
        end
    end

    // pack valid tokens into the low write slots and flag the last one
    always_comb begin
        q_wr.count = 2'd0;
        q_wr.tok0  = ta;
        q_wr.tok1  = tb;
        if (accept) begin
            if (va && vb) begin
                q_wr.count     = 2'd2;
                q_wr.tok1.last = 1'b1;
            end else if (va) begin
                q_wr.count     = 2'd1;
                q_wr.tok0.last = 1'b1;
            end else if (vb) begin
                q_wr.count     = 2'd1;
                q_wr.tok0      = tb;
                q_wr.tok0.last = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            begin_reg <= '0;
            pos_reg   <= '0;
            held_reg  <= '0;
            seen_reg  <= 1'b0;
        end else if (accept) begin
            state_reg <= state_next;
            begin_reg <= begin_next;
            pos_reg   <= pos_next;
            held_reg  <= held_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

// ===== design/etl_queue.sv =====
// ----------------------------------------------------------------------------
// etl_queue
// Small token queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module etl_queue
    import etl_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  queue_wr_t     q_wr,
    input  logic          rd_en,
    output token_t        rd_tok,
    output queue_status_t q_status
);

    token_t               slot_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic                 do_rd;

    assign do_rd = rd_en && (count_reg != '0);

    assign wr_ptr_next = wr_ptr_reg + QPTR_BITS'(q_wr.count);
    assign rd_ptr_next = rd_ptr_reg + QPTR_BITS'(do_rd);
    assign count_next  = count_reg + QCNT_BITS'(q_wr.count) - QCNT_BITS'(do_rd);

    assign rd_tok            = slot_reg[rd_ptr_reg];
    assign q_status.count    = count_reg;

    always_ff @(posedge aclk) begin
        if (q_wr.count != 2'd0) begin
            slot_reg[wr_ptr_reg] <= q_wr.tok0;
        end
        if (q_wr.count == 2'd2) begin
            slot_reg[wr_ptr_reg + 1'b1] <= q_wr.tok1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/etl_back.sv =====
// ----------------------------------------------------------------------------
// etl_back
// Output stage: pulls tokens from the queue into a result register and
// holds each one until the downstream side takes it.
// ----------------------------------------------------------------------------
module etl_back
    import etl_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  queue_status_t q_status,
    input  token_t        rd_tok,
    output logic          rd_en,
    output logic          out_valid,
    input  logic          out_ready,
    output token_t        out_tok
);

    logic   valid_reg, valid_next;
    token_t tok_reg;
    logic   load;

    assign load       = (q_status.count != '0) && (!valid_reg || out_ready);
    assign rd_en      = load;
    assign valid_next = load ? 1'b1 : (valid_reg && !out_ready);

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tok_reg <= rd_tok;
        end
    end

endmodule

// ===== design/expression_token_lexer.sv =====
// ----------------------------------------------------------------------------
// expression_token_lexer
// Streaming lexer for expression text: bytes in, kind/offset tokens out.
// ----------------------------------------------------------------------------
// One character per transaction on the slave side, s_tlast marks the end item
// (s_tdata is ignored then). Each transaction is classified in the cycle it is
// taken and yields zero, one or two tokens, which go through a four-entry
// queue to the result register, so the block takes one byte per cycle
// whenever the queue has room for two tokens; each token is written into the
// queue and then loaded into the result register. The result stream sustains
// one token per cycle while m_tready is high, so long runs of two-token
// transactions (an operator right after an identifier or number) slow the input.
// m_tlast marks the last token caused by one input transaction, m_tuser marks
// the end token or an error, which closes the text; bytes after an error are
// dropped until the end item.
// ----------------------------------------------------------------------------
module expression_token_lexer
    import etl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [4:0] token_kind, [20:5] token_start,
                                   // [36:21] token_end, [39:37] error_code
    output logic        m_tlast,   // run_last
    output logic [0:0]  m_tuser    // [0] text_done
);

    queue_wr_t     q_wr;
    queue_status_t q_status;
    token_t        rd_tok;
    token_t        out_tok;
    logic          rd_en;

    etl_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_end   (s_tlast),
        .q_status (q_status),
        .q_wr     (q_wr)
    );

    etl_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_wr     (q_wr),
        .rd_en    (rd_en),
        .rd_tok   (rd_tok),
        .q_status (q_status)
    );

    etl_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .rd_tok    (rd_tok),
        .rd_en     (rd_en),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (out_tok)
    );

    assign m_tdata = {out_tok.err, out_tok.tok_end, out_tok.tok_start, out_tok.kind};
    assign m_tlast = out_tok.last;
    assign m_tuser = out_tok.done;

    // queue never overfills
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.count <= QCNT_BITS'(QDEPTH))
        else $error("token queue overflow");

    // an error result is always an end-kind token that closes the text
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[39:37] != ERR_NONE) |-> (m_tdata[4:0] == K_END) && m_tuser[0])
        else $error("error result without end kind or close flag");

    // a closing token is always the last one of its transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("closing token not marked last");

endmodule
